[design/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared constants and types for the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

    localparam int NUM_ENTRIES = 8;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > 3) ? CNT_W : 3;

    localparam int TIME_W      = 16;
    localparam int SUM_W       = 24;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // candidate handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bur;
    } cand_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic              load;
        logic              dec;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] now;
    } cell_ctl_t;

endpackage

`default_nettype wire

[design/srtf_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// srtf_scheduler_unit
// Preemptive shortest-remaining-time-first scheduler over a row of job cells.
// ----------------------------------------------------------------------------
//  channel  dir  signals                          beat
//  s_axis   in   s_tvalid s_tready s_tdata s_tuser one load or one tick
//  m_axis   out  m_tvalid m_tready m_tdata         one result per input beat
//
//  Load: the cell is written, then the result register is loaded.
//  Tick: SCAN while the candidate walks the cell row one hop a cycle, then APPLY and REPORT.
//  One item at a time; the next input beat is taken once the result is loaded.
//  A stalled result holds the output register; the block waits in REPORT.
//  rst_n clears all entries, the tick counter and both sums.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_scheduler_unit (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // [2:0] entry_index, [18:3] arrival_time, [34:19] burst_time
    input  wire [srtf_pkg::IN_TDATA_W-1:0]       s_tdata,
    // [0] kind
    input  wire                                  s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // [2:0] ran_index, [3] idle, [4] completed, [20:5] turnaround,
    // [36:21] waiting, [60:37] wait_total, [84:61] turnaround_total,
    // [85] all_done, [101:86] current_tick
    output logic [srtf_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import srtf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] tick_reg, tick_next;
    logic [SUM_W-1:0]  wsum_reg, wsum_next;
    logic [SUM_W-1:0]  tsum_reg, tsum_next;

    logic [2:0]        res_ran_reg;
    logic              res_idle_reg;
    logic              res_done_reg;
    logic [TIME_W-1:0] res_turn_reg;
    logic [TIME_W-1:0] res_wait_reg;
    logic [TIME_W-1:0] res_now_reg;

    logic              out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic              in_fire;
    logic              in_kind;
    logic [2:0]        in_idx;
    logic [TIME_W-1:0] in_arr;
    logic [TIME_W-1:0] in_bur;
    logic              load_ok;

    cand_t             seed;
    cand_t             chain [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] busy;
    cell_ctl_t         ctl [NUM_ENTRIES];
    cand_t             win;

    logic [TIME_W:0]   finish;
    logic [TIME_W:0]   turn_full;
    logic [TIME_W-1:0] turn_sat;
    logic [TIME_W-1:0] wait_val;
    logic [SUM_W:0]    wsum_add;
    logic [SUM_W:0]    tsum_add;
    logic              win_done;
    logic              out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign in_kind  = s_tuser;
    assign in_idx   = s_tdata[2:0];
    assign in_arr   = s_tdata[18:3];
    assign in_bur   = s_tdata[34:19];
    assign load_ok  = CMP_W'(in_idx) < CMP_W'(NUM_ENTRIES);
    assign s_tready = (state_reg == ST_IDLE);
    assign seed     = '0;
    assign win      = chain[NUM_ENTRIES-1];
    assign out_free = !out_valid_reg || m_tready;

    genvar g;
    generate
        for (g = 0; g < NUM_ENTRIES; g++)
        begin : g_cell
            always_comb
            begin
                ctl[g].load    = in_fire && (in_kind == KIND_LOAD) && load_ok &&
                                 (IDX_W'(in_idx) == IDX_W'(g));
                ctl[g].dec     = (state_reg == ST_APPLY) && win.valid &&
                                 (win.idx == IDX_W'(g));
                ctl[g].arrival = in_arr;
                ctl[g].burst   = in_bur;
                ctl[g].now     = tick_reg;
            end

            srtf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(g)),
                .ctl      (ctl[g]),
                .cand_in  ((g == 0) ? seed : chain[(g == 0) ? 0 : g-1]),
                .cand_out (chain[g]),
                .busy     (busy[g])
            );
        end
    endgenerate

    always_comb
    begin
        finish    = {1'b0, tick_reg} + (TIME_W+1)'(1);
        turn_full = finish - {1'b0, win.arr};
        turn_sat  = turn_full[TIME_W] ? '1 : turn_full[TIME_W-1:0];
        wait_val  = (turn_sat > win.bur) ? (turn_sat - win.bur) : '0;
        wsum_add  = {1'b0, wsum_reg} + (SUM_W+1)'(wait_val);
        tsum_add  = {1'b0, tsum_reg} + (SUM_W+1)'(turn_sat);
        win_done  = win.valid && (win.rem == TIME_W'(1));
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tick_next  = tick_reg;
        wsum_next  = wsum_reg;
        tsum_next  = tsum_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next   = '0;
                    state_next = (in_kind == KIND_TICK) ? ST_SCAN : ST_REPORT;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_ENTRIES - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (win_done)
                begin
                    wsum_next = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
                    tsum_next = tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
                end
                if (tick_reg != '1)
                begin
                    tick_next = tick_reg + TIME_W'(1);
                end
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tick_reg  <= tick_next;
            wsum_reg  <= wsum_next;
            tsum_reg  <= tsum_next;
            if ((state_reg == ST_REPORT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_ran_reg  <= '0;
            res_idle_reg <= 1'b1;
            res_done_reg <= 1'b0;
            res_turn_reg <= '0;
            res_wait_reg <= '0;
            res_now_reg  <= tick_reg;
        end
        else if (state_reg == ST_APPLY)
        begin
            res_ran_reg  <= win.valid ? 3'(win.idx) : 3'd0;
            res_idle_reg <= !win.valid;
            res_done_reg <= win_done;
            res_turn_reg <= win_done ? turn_sat : '0;
            res_wait_reg <= win_done ? wait_val : '0;
        end
        if ((state_reg == ST_REPORT) && out_free)
        begin
            out_data_reg <= {2'b00, res_now_reg, ~(|busy), tsum_reg, wsum_reg,
                             res_wait_reg, res_turn_reg, res_done_reg,
                             res_idle_reg, res_ran_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |-> !m_tdata[3])
        else $error("completion reported on an idle beat");

    a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (tick_reg >= $past(tick_reg)))
        else $error("tick counter went backwards");

    a_sums_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((wsum_reg >= $past(wsum_reg)) && (tsum_reg >= $past(tsum_reg))))
        else $error("running sum went backwards");

    a_tick_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_APPLY) |=> $stable(tick_reg))
        else $error("tick moved outside apply");

endmodule

`default_nettype wire

[design/srtf_cell.sv]
// ----------------------------------------------------------------------------
// srtf_cell
// One job entry: holds arrival, burst and remaining time, and merges its own
// bid with the candidate from its left neighbor, one hop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_cell (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire [srtf_pkg::IDX_W-1:0] cell_idx,
    input  srtf_pkg::cell_ctl_t     ctl,
    input  srtf_pkg::cand_t         cand_in,
    output srtf_pkg::cand_t         cand_out,
    output logic                    busy
);
    import srtf_pkg::*;

    logic [TIME_W-1:0] arr_reg, arr_next;
    logic [TIME_W-1:0] bur_reg, bur_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    cand_t             cand_reg, cand_next;
    logic              eligible;

    always_comb
    begin
        arr_next = arr_reg;
        bur_next = bur_reg;
        rem_next = rem_reg;
        if (ctl.load)
        begin
            arr_next = ctl.arrival;
            bur_next = ctl.burst;
            rem_next = ctl.burst;
        end
        else if (ctl.dec)
        begin
            rem_next = rem_reg - TIME_W'(1);
        end
    end

    assign eligible = (arr_reg <= ctl.now) && (rem_reg != '0);

    always_comb
    begin
        cand_next = cand_in;
        if (eligible && (!cand_in.valid || (rem_reg < cand_in.rem)))
        begin
            cand_next.valid = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.rem   = rem_reg;
            cand_next.arr   = arr_reg;
            cand_next.bur   = bur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arr_reg  <= '0;
            bur_reg  <= '0;
            rem_reg  <= '0;
            cand_reg <= '0;
        end
        else
        begin
            arr_reg  <= arr_next;
            bur_reg  <= bur_next;
            rem_reg  <= rem_next;
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;
    assign busy     = (rem_reg != '0);

    a_cand_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg.valid |-> (cand_reg.rem != '0))
        else $error("candidate with no remaining work");

    a_dec_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.dec && !ctl.load) |-> (rem_reg != '0))
        else $error("decrement of an idle entry");

    a_dec_steps_one: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.dec && !ctl.load) |=> (rem_reg == $past(rem_reg) - TIME_W'(1)))
        else $error("remaining time did not step by one");

endmodule

`default_nettype wire
